[sv/swamm_pkg.sv]
// Package for the sliding window alpha max/min filter.
// Holds the window geometry constants and cell control struct used by the
// top level, and the compare function used by the cell. No dependencies.
`default_nettype none

package swamm_pkg;

  localparam int unsigned MaxRadius = 63;
  localparam int unsigned WinDepth  = 2 * MaxRadius + 1;
  localparam int unsigned IdxW      = $clog2(WinDepth);
  localparam int unsigned RadW      = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned AlphaW    = 8;

  // Configuration register indexes
  localparam logic CfgRadius = 1'b0;
  localparam logic CfgShrink = 1'b1;

  // Control shared by every cell of the window chain
  typedef struct packed {
    logic            push;    // shift samples one cell toward the old end
    logic            clr;     // clear all samples to zero
    logic            start;   // seed the accumulator at the top cell
    logic            acc_en;  // move accumulators one cell toward cell 0
    logic            shrink;  // 1: minimum, 0: maximum
    logic [IdxW-1:0] top;     // index of the oldest sample in the window
  } ctrl_t;

  // Pick the larger (grow) or smaller (shrink) of two samples
  function automatic logic [AlphaW-1:0] pick(input logic [AlphaW-1:0] a,
                                             input logic [AlphaW-1:0] b,
                                             input logic              shrink);
    logic [AlphaW-1:0] res;
    if (shrink) begin
      res = (b < a) ? b : a;
    end else begin
      res = (b > a) ? b : a;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/sliding_window_alpha_max_min.sv]
// Top level of the sliding window alpha max/min filter.
// Controller, configuration registers, output register and the cell chain.
// Depends on swamm_pkg and swamm_cell.
//
// Usage:
//   s_axis carries one alpha sample per beat (tdata[7:0]), tlast marks the
//   last sample of a line. m_axis gives one result per beat: tdata[7:0] is
//   the window max (grow) or min (shrink), tuser[0] marks the last result
//   caused by one input beat, tlast marks the last position of the line.
//   The cfg port writes window_radius (index 0) and shrink_mode (index 1).
//   It is always ready. It is to be written only while the block is idle;
//   the block itself does not enforce this.
// Sequence, with r the radius:
//   A sample that completes a window seeds the accumulator at the top cell;
//   the accumulator folds down the chain to cell 0, and the result is
//   loaded into the output register once that is free; the next sample is
//   taken after the load. A sample that gives no result is taken without a
//   scan. The line end adds r flush steps, each shifting in a zero and
//   scanning like a sample when it gives a result, then clears the window.
// Reset clears the window to zeros, the sample count, the radius to 1 and
// the mode to grow. When the receiver stalls the result holds in the output
// register; the block finishes at most one more result and then waits.
`default_nettype none

module sliding_window_alpha_max_min (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream; tdata: alpha_in[7:0]
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tlast,
  // output stream; tdata: alpha_out[7:0]; tuser: run_last[0]
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  output logic [0:0]      m_axis_tuser,
  output logic            m_axis_tlast,
  // configuration writes
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [5:0] cfg_data_i
);

  localparam int unsigned IdxW  = swamm_pkg::IdxW;
  localparam int unsigned CntW  = swamm_pkg::CntW;
  localparam int unsigned RadW  = swamm_pkg::RadW;
  localparam int unsigned Depth = swamm_pkg::WinDepth;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]      state_d, state_q;
  logic [RadW-1:0] radius_q;
  logic            shrink_q;
  logic [CntW-1:0] count_d, count_q;
  logic [RadW-1:0] k_d, k_q;
  logic [IdxW-1:0] scan_d, scan_q;
  logic            last_d, last_q;
  logic            fin_d, fin_q;
  logic            out_valid_d, out_valid_q;
  logic [7:0]      out_data_q;
  logic            out_run_q, out_line_q;

  logic            in_acc, slot_free, load;
  logic [RadW-1:0] rad;
  logic [CntW:0]   count_inc;
  logic [CntW:0]   flush_sum;
  logic [RadW:0]   k_next;
  logic [7:0]      din;
  swamm_pkg::ctrl_t ctrl;

  logic [7:0] samp_w [Depth];
  logic [7:0] acc_w  [Depth+1];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(1);
      shrink_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swamm_pkg::CfgRadius: radius_q <= cfg_data_i;
        swamm_pkg::CfgShrink: shrink_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rad = (32'(radius_q) > swamm_pkg::MaxRadius) ?
               RadW'(swamm_pkg::MaxRadius) : radius_q;

  // Handshake terms
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign load          = (state_q == StScan) && (scan_q == '0) && slot_free;

  assign count_inc = {1'b0, count_q} + (CntW+1)'(1);
  assign k_next    = {1'b0, k_q} + (RadW+1)'(1);
  assign flush_sum = {1'b0, count_q} + (CntW+1)'(k_next);

  // Controller
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    scan_d      = scan_q;
    last_d      = last_q;
    fin_d       = fin_q;
    din         = 8'h00;
    ctrl.push   = 1'b0;
    ctrl.clr    = 1'b0;
    ctrl.start  = 1'b0;
    ctrl.acc_en = 1'b0;
    ctrl.shrink = shrink_q;
    ctrl.top    = IdxW'({rad, 1'b0});

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          din       = s_axis_tdata;
          ctrl.push = 1'b1;
          count_d   = (count_q == {CntW{1'b1}}) ? count_q : count_inc[CntW-1:0];
          last_d    = s_axis_tlast;
          k_d       = '0;
          if (count_inc > (CntW+1)'(rad)) begin
            ctrl.start = 1'b1;
            scan_d     = ctrl.top;
            fin_d      = !s_axis_tlast || (rad == '0);
            state_d    = StScan;
          end else if (s_axis_tlast) begin
            state_d = StFlush;
          end
        end
      end
      StScan: begin
        if (scan_q != '0) begin
          ctrl.acc_en = 1'b1;
          scan_d      = scan_q - IdxW'(1);
        end else if (slot_free) begin
          if (fin_q) begin
            if (last_q) begin
              ctrl.clr = 1'b1;
              count_d  = '0;
            end
            state_d = StIdle;
          end else begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        // shift one zero in past the line end
        ctrl.push = 1'b1;
        k_d       = k_next[RadW-1:0];
        if (flush_sum > (CntW+1)'(rad)) begin
          ctrl.start = 1'b1;
          scan_d     = ctrl.top;
          fin_d      = (k_next == (RadW+1)'(rad));
          state_d    = StScan;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      k_q     <= '0;
      scan_q  <= '0;
      last_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      scan_q  <= scan_d;
      last_q  <= last_d;
      fin_q   <= fin_d;
    end
  end

  // Cell chain; cell 0 takes the new sample and gives the window result
  assign acc_w[Depth] = 8'h00;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    swamm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .idx_i  (IdxW'(i)),
      .samp_i ((i == 0) ? din : samp_w[(i == 0) ? 0 : i-1]),
      .acc_i  (acc_w[i+1]),
      .samp_o (samp_w[i]),
      .acc_o  (acc_w[i])
    );
  end

  // Output register
  assign out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= acc_w[0];
      out_run_q  <= fin_q;
      out_line_q <= fin_q && last_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_run_q;
  assign m_axis_tlast    = out_line_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (scan_q <= ctrl.top))
    else $error("scan counter beyond window top");

  a_flush_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (last_q && (k_q < rad)))
    else $error("flush step outside a line end");

  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clr |-> (last_q && fin_q && load))
    else $error("window cleared before the final line result");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

[sv/swamm_cell.sv]
// One cell of the window chain: holds one sample and one partial result.
// Samples move toward higher indexes, the accumulator toward cell 0.
// Depends on swamm_pkg.
`default_nettype none

module swamm_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swamm_pkg::ctrl_t             ctrl_i,
  input  wire logic [swamm_pkg::IdxW-1:0]   idx_i,
  input  wire logic [swamm_pkg::AlphaW-1:0] samp_i,
  input  wire logic [swamm_pkg::AlphaW-1:0] acc_i,
  output logic      [swamm_pkg::AlphaW-1:0] samp_o,
  output logic      [swamm_pkg::AlphaW-1:0] acc_o
);

  logic [swamm_pkg::AlphaW-1:0] samp_d, samp_q;
  logic [swamm_pkg::AlphaW-1:0] acc_d, acc_q;

  // Sample register: clear, shift, or hold
  always_comb begin
    if (ctrl_i.clr) begin
      samp_d = '0;
    end else if (ctrl_i.push) begin
      samp_d = samp_i;
    end else begin
      samp_d = samp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else begin
      samp_q <= samp_d;
    end
  end

  // Accumulator: seeded at the top cell, then folded down the chain
  always_comb begin
    if (ctrl_i.start && (idx_i == ctrl_i.top)) begin
      acc_d = samp_d;
    end else if (ctrl_i.acc_en) begin
      acc_d = swamm_pkg::pick(acc_i, samp_q, ctrl_i.shrink);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign samp_o = samp_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire
